@@ rtl/core/mi3_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse block.
package mi3_pkg;

   localparam int IN_WIDTH    = 16;
   localparam int FRAC_IN     = 8;
   localparam int FRAC_OUT    = 16;
   localparam int SCALE_SHIFT = FRAC_IN + FRAC_OUT;
   localparam int OUT_WIDTH   = 32;
   localparam int CW          = 2 * IN_WIDTH + 1;
   localparam int PW          = IN_WIDTH + CW;
   localparam int DW          = PW + 2;
   localparam int QBITS       = OUT_WIDTH + 2;
   localparam int LOW_BITS    = QBITS - (SCALE_SHIFT + 1);
   localparam int FRONT_ST    = 3;
   localparam int LANE_ST     = QBITS + 1;
   localparam int NUM_ST      = FRONT_ST + LANE_ST + 1;

   localparam logic [OUT_WIDTH-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [OUT_WIDTH-1:0] SAT_NEG = 32'h8000_0000;

   typedef logic signed [IN_WIDTH-1:0]  elem_type;
   typedef logic signed [CW-1:0]        cof_type;
   typedef cof_type [8:0]               cof_vec_type;
   typedef logic signed [DW-1:0]        det_type;
   typedef logic signed [OUT_WIDTH-1:0] res_type;

   typedef struct packed {
      elem_type a00;
      elem_type a01;
      elem_type a02;
      elem_type a10;
      elem_type a11;
      elem_type a12;
      elem_type a20;
      elem_type a21;
      elem_type a22;
   } req_type;

   typedef struct packed {
      res_type r00;
      res_type r01;
      res_type r02;
      res_type r10;
      res_type r11;
      res_type r12;
      res_type r20;
      res_type r21;
      res_type r22;
      logic    singular;
   } rsp_type;

endpackage

@@ rtl/core/mi3_front.sv @@
// Cofactor and determinant pipeline: three register stages.
module mi3_front
   import mi3_pkg::*;
(
   input  logic                clock,
   input  logic [FRONT_ST-1:0] en,
   input  req_type             req,
   output cof_vec_type         cof,
   output det_type             det
);

   elem_type mat [3][3];
   cof_type  cof1_ff [9];
   cof_type  cof2_ff [9];
   cof_type  cof3_ff [9];
   elem_type row_ff [3];
   logic signed [PW-1:0] prod_ff [3];
   det_type  det_ff;

   assign mat[0][0] = req.a00;
   assign mat[0][1] = req.a01;
   assign mat[0][2] = req.a02;
   assign mat[1][0] = req.a10;
   assign mat[1][1] = req.a11;
   assign mat[1][2] = req.a12;
   assign mat[2][0] = req.a20;
   assign mat[2][1] = req.a21;
   assign mat[2][2] = req.a22;

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         localparam int R1 = (r == 0) ? 1 : 0;
         localparam int R2 = (r == 2) ? 1 : 2;
         localparam int C1 = (c == 0) ? 1 : 0;
         localparam int C2 = (c == 2) ? 1 : 2;
         logic signed [2*IN_WIDTH-1:0] p1;
         logic signed [2*IN_WIDTH-1:0] p2;
         cof_type minor;
         cof_type cof_in;
         always_comb begin
            p1     = mat[R1][C1] * mat[R2][C2];
            p2     = mat[R1][C2] * mat[R2][C1];
            minor  = CW'(p1) - CW'(p2);
            cof_in = (((r + c) % 2) == 1) ? -minor : minor;
         end
         always_ff @(posedge clock) begin
            if (en[0]) begin
               cof1_ff[r*3+c] <= cof_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         row_ff[0] <= mat[0][0];
         row_ff[1] <= mat[0][1];
         row_ff[2] <= mat[0][2];
      end
      if (en[1]) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[j] <= row_ff[j] * cof1_ff[j];
         end
         cof2_ff <= cof1_ff;
      end
      if (en[2]) begin
         det_ff  <= DW'(prod_ff[0]) + DW'(prod_ff[1]) + DW'(prod_ff[2]);
         cof3_ff <= cof2_ff;
      end
   end

   always_comb begin
      for (int n = 0; n < 9; n++) begin
         cof[n] = cof3_ff[n];
      end
   end

   assign det = det_ff;

endmodule

@@ rtl/core/mi3_lane.sv @@
// One division lane: rounded, saturated cofactor over determinant, one bit per stage.
module mi3_lane
   import mi3_pkg::*;
(
   input  logic               clock,
   input  logic [LANE_ST-1:0] en,
   input  cof_type            cof,
   input  det_type            det,
   output res_type            res
);

   logic [CW-1:0]       cmag;
   logic [DW-1:0]       dmag_in;
   logic [CW-1:0]       hi_part;
   logic                ovf_in;

   logic [DW-1:0]       rem_ff  [LANE_ST];
   logic [DW-1:0]       dmag_ff [LANE_ST];
   logic [LOW_BITS-1:0] low_ff  [LANE_ST];
   logic [QBITS-1:0]    q_ff    [LANE_ST];
   logic                neg_ff  [LANE_ST];
   logic                ovf_ff  [LANE_ST];

   logic [QBITS:0]      qr;

   always_comb begin
      cmag    = cof[CW-1] ? CW'(-cof) : CW'(cof);
      dmag_in = det[DW-1] ? DW'(-det) : DW'(det);
      hi_part = cmag >> LOW_BITS;
      ovf_in  = DW'(hi_part) >= dmag_in;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= ovf_in ? '0 : DW'(hi_part);
         dmag_ff[0] <= dmag_in;
         low_ff[0]  <= cmag[LOW_BITS-1:0];
         q_ff[0]    <= '0;
         neg_ff[0]  <= cof[CW-1] ^ det[DW-1];
         ovf_ff[0]  <= ovf_in;
      end
   end

   for (genvar k = 1; k < LANE_ST; k++) begin : g_step
      logic [DW:0]   trial;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [DW:0]   diff;
      always_comb begin
         trial  = {rem_ff[k-1], low_ff[k-1][LOW_BITS-1]};
         take   = trial >= {1'b0, dmag_ff[k-1]};
         diff   = trial - {1'b0, dmag_ff[k-1]};
         rem_in = take ? diff[DW-1:0] : trial[DW-1:0];
      end
      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in;
            dmag_ff[k] <= dmag_ff[k-1];
            low_ff[k]  <= {low_ff[k-1][LOW_BITS-2:0], 1'b0};
            q_ff[k]    <= {q_ff[k-1][QBITS-2:0], take};
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   // The quotient holds twice the exact ratio, so one more and a halving rounds it.
   always_comb begin
      qr = ({1'b0, q_ff[LANE_ST-1]} + (QBITS+1)'(1)) >> 1;
      if (neg_ff[LANE_ST-1]) begin
         if (ovf_ff[LANE_ST-1] || qr > (QBITS+1)'(SAT_NEG)) begin
            res = res_type'(SAT_NEG);
         end else begin
            res = res_type'(-qr[OUT_WIDTH-1:0]);
         end
      end else begin
         if (ovf_ff[LANE_ST-1] || qr > (QBITS+1)'(SAT_POS)) begin
            res = res_type'(SAT_POS);
         end else begin
            res = res_type'(qr[OUT_WIDTH-1:0]);
         end
      end
   end

endmodule

@@ rtl/core/mat3_inverse.sv @@
// Top level of the 3x3 fixed-point matrix inverse pipeline.
//
// One beat on the req_ channel carries a 3x3 matrix of signed Q8.8 elements.
// One beat on the rsp_ channel carries its inverse in signed Q16.16, saturated,
// with the singular flag set and all entries zero when the determinant is zero.
// Each entry is the transposed cofactor over the determinant, rounded to
// nearest with ties away from zero.
// A beat moves when valid is high and stall is low at a rising clock edge.
// The front stages form the cofactors and the determinant, nine division lanes
// each run a setup stage and then one quotient bit per stage for 34 bits, and
// one output register merges the lanes.
// Throughput is one matrix per cycle while rsp_stall stays low.
// When the receiver stalls, the output beat holds and the stages behind it
// keep filling their empty slots; req_stall rises only when every stage holds
// a beat.
// Synchronous reset empties the pipeline; no response beat follows reset
// until new requests arrive.
module mat3_inverse
   import mi3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [NUM_ST-1:0] vld_ff;
   logic [NUM_ST-1:0] en;
   cof_vec_type       cof;
   det_type           det;
   res_type           res [9];
   logic              sing_ff [LANE_ST];
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   always_comb begin
      en[NUM_ST-1] = !vld_ff[NUM_ST-1] || !rsp_stall;
      for (int k = NUM_ST - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_ST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   mi3_front u_front (
      .clock (clock),
      .en    (en[FRONT_ST-1:0]),
      .req   (req_data),
      .cof   (cof),
      .det   (det)
   );

   for (genvar i = 0; i < 3; i++) begin : g_ri
      for (genvar j = 0; j < 3; j++) begin : g_rj
         mi3_lane u_lane (
            .clock (clock),
            .en    (en[FRONT_ST+LANE_ST-1:FRONT_ST]),
            .cof   (cof[j*3+i]),
            .det   (det),
            .res   (res[i*3+j])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en[FRONT_ST]) begin
         sing_ff[0] <= (det == '0);
      end
      for (int k = 1; k < LANE_ST; k++) begin
         if (en[FRONT_ST+k]) begin
            sing_ff[k] <= sing_ff[k-1];
         end
      end
   end

   always_comb begin
      rsp_in.singular = sing_ff[LANE_ST-1];
      if (sing_ff[LANE_ST-1]) begin
         rsp_in.r00 = '0;
         rsp_in.r01 = '0;
         rsp_in.r02 = '0;
         rsp_in.r10 = '0;
         rsp_in.r11 = '0;
         rsp_in.r12 = '0;
         rsp_in.r20 = '0;
         rsp_in.r21 = '0;
         rsp_in.r22 = '0;
      end else begin
         rsp_in.r00 = res[0];
         rsp_in.r01 = res[1];
         rsp_in.r02 = res[2];
         rsp_in.r10 = res[3];
         rsp_in.r11 = res[4];
         rsp_in.r12 = res[5];
         rsp_in.r20 = res[6];
         rsp_in.r21 = res[7];
         rsp_in.r22 = res[8];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NUM_ST-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[NUM_ST-1];
   assign rsp_data  = rsp_ff;

   // A singular matrix gives an all-zero inverse.
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.r00 == 0 && rsp_data.r01 == 0 && rsp_data.r02 == 0 &&
         rsp_data.r10 == 0 && rsp_data.r11 == 0 && rsp_data.r12 == 0 &&
         rsp_data.r20 == 0 && rsp_data.r21 == 0 && rsp_data.r22 == 0)
      else $error("singular response with nonzero entries");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && vld_ff == '0)
      else $error("pipeline not empty after reset");

   // Requests stall only when every stage is full and the output is stalled.
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("request stalled with a free stage");

endmodule

@@ tb/mat3_inverse_tb.sv @@
// Self-checking testbench for the 3x3 matrix inverse pipeline.
module mat3_inverse_tb;
   import mi3_pkg::*;

   localparam int LATENCY = 39;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1330;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type inverse_queue[$];
   int      error_count;
   int      cycle_count;

   typedef struct {
      req_type mat;
      logic    typed;
      rsp_type inv;
   } stim_row_type;

   stim_row_type directed_rows[$];

   mat3_inverse uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] scale_entry(logic signed [63:0] cof,
                                                       logic signed [63:0] det);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      logic         negative;
      negative = cof[63] ^ det[63];
      num = 128'(cof < 0 ? -cof : cof) << SCALE_SHIFT;
      den = 128'(det < 0 ? -det : det);
      quo = (2 * num + den) / (2 * den);
      if (negative) begin
         if (quo > 128'h8000_0000) return SAT_NEG;
         return -quo[31:0];
      end
      if (quo > 128'h7FFF_FFFF) return SAT_POS;
      return quo[31:0];
   endfunction

   function automatic rsp_type predict_inverse(req_type mat);
      logic signed [63:0] m[3][3];
      logic signed [63:0] c[3][3];
      logic signed [63:0] det;
      logic signed [31:0] e[9];
      rsp_type            inv;
      int                 r1, r2, c1, c2;
      m[0][0] = mat.a00; m[0][1] = mat.a01; m[0][2] = mat.a02;
      m[1][0] = mat.a10; m[1][1] = mat.a11; m[1][2] = mat.a12;
      m[2][0] = mat.a20; m[2][1] = mat.a21; m[2][2] = mat.a22;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            r1 = (i == 0) ? 1 : 0; r2 = (i == 2) ? 1 : 2;
            c1 = (j == 0) ? 1 : 0; c2 = (j == 2) ? 1 : 2;
            c[i][j] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
            if ((i + j) % 2 == 1) c[i][j] = -c[i][j];
         end
      end
      det = m[0][0] * c[0][0] + m[0][1] * c[0][1] + m[0][2] * c[0][2];
      if (det == 0) begin
         inv = '0;
         inv.singular = 1'b1;
         return inv;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            e[i * 3 + j] = scale_entry(c[j][i], det);
      inv.r00 = e[0]; inv.r01 = e[1]; inv.r02 = e[2];
      inv.r10 = e[3]; inv.r11 = e[4]; inv.r12 = e[5];
      inv.r20 = e[6]; inv.r21 = e[7]; inv.r22 = e[8];
      inv.singular = 1'b0;
      return inv;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   function automatic req_type random_matrix();
      req_type mat;
      int      mode;
      mode = $urandom_range(0, 9);
      mat = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if (mode < 3) begin
         // Small elements give well-conditioned and moderately sized inverses.
         mat.a00 = elem_type'($urandom_range(0, 2047) - 1024);
         mat.a01 = elem_type'($urandom_range(0, 511) - 256);
         mat.a02 = elem_type'($urandom_range(0, 511) - 256);
         mat.a10 = elem_type'($urandom_range(0, 511) - 256);
         mat.a11 = elem_type'($urandom_range(0, 2047) - 1024);
         mat.a12 = elem_type'($urandom_range(0, 511) - 256);
         mat.a20 = elem_type'($urandom_range(0, 511) - 256);
         mat.a21 = elem_type'($urandom_range(0, 511) - 256);
         mat.a22 = elem_type'($urandom_range(0, 2047) - 1024);
      end else if (mode == 3) begin
         // Repeating a row makes the matrix singular.
         mat.a20 = mat.a00; mat.a21 = mat.a01; mat.a22 = mat.a02;
      end else if (mode == 4) begin
         mat.a01 = '0; mat.a02 = '0; mat.a10 = '0; mat.a12 = '0; mat.a20 = '0; mat.a21 = '0;
         mat.a11 = elem_type'($urandom_range(0, 15) - 8);
      end else if (mode == 5) begin
         mat.a00 = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         mat.a22 = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      return mat;
   endfunction

   function automatic req_type diag_matrix(elem_type d0, elem_type d1, elem_type d2);
      req_type mat;
      mat = '0;
      mat.a00 = d0;
      mat.a11 = d1;
      mat.a22 = d2;
      return mat;
   endfunction

   function automatic rsp_type diag_inverse(res_type v0, res_type v1, res_type v2);
      rsp_type inv;
      inv = '0;
      inv.r00 = v0;
      inv.r11 = v1;
      inv.r22 = v2;
      return inv;
   endfunction

   task automatic add_row(req_type mat, logic typed, rsp_type inv);
      stim_row_type row;
      row.mat = mat;
      row.typed = typed;
      row.inv = inv;
      directed_rows.push_back(row);
   endtask

   task automatic send_matrix(req_type mat);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= mat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      req_type mat;
      rsp_type none;
      none = '0;
      error_count = 0;
      req_valid   = 1'b0;
      req_data    = '0;
      reset       = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Identity, scaled diagonals, zero, extreme and general matrices.
      add_row(diag_matrix(16'sh0100, 16'sh0100, 16'sh0100), 1'b1,
              diag_inverse(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
      add_row(diag_matrix(16'sh0200, -16'sh0100, 16'sh0080), 1'b1,
              diag_inverse(32'sh0000_8000, -32'sh0001_0000, 32'sh0002_0000));
      mat = '0;
      add_row(mat, 1'b1, rsp_type'(1));
      add_row(req_type'({9{16'sh7FFF}}), 1'b1, rsp_type'(1));
      add_row(req_type'({9{16'sh8000}}), 1'b1, rsp_type'(1));
      add_row(diag_matrix(16'sh0001, 16'sh0001, 16'sh0001), 1'b1,
              diag_inverse(32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000));
      add_row(diag_matrix(-16'sh0001, -16'sh0001, -16'sh0001), 1'b1,
              diag_inverse(-32'sh0100_0000, -32'sh0100_0000, -32'sh0100_0000));
      add_row(diag_matrix(16'sh7FFF, 16'sh8000, 16'sh7FFF), 1'b0, none);
      add_row(diag_matrix(16'sh8000, 16'sh8000, 16'sh8000), 1'b0, none);
      add_row(req_type'({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                         16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFE}), 1'b0, none);
      add_row(req_type'({16'sh0100, 16'sh0200, 16'sh0300, 16'sh0000, 16'sh0100,
                         16'sh0400, 16'sh0500, 16'sh0600, 16'sh0000}), 1'b0, none);
      add_row(req_type'({16'sh0003, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100,
                         16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100}), 1'b0, none);
      add_row(req_type'({16'sh0000, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000,
                         16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000}), 1'b0, none);
      add_row(req_type'({16'sh1234, -16'sh0567, 16'sh0089, 16'sh0abc, 16'sh0def,
                         -16'sh0111, 16'sh0222, 16'sh0333, -16'sh0444}), 1'b0, none);
      add_row(req_type'({16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                         16'shAAAB, 16'sh5556, 16'shAAAA, 16'sh5555}), 1'b0, none);

      foreach (directed_rows[k]) begin
         inverse_queue.push_back(directed_rows[k].typed ? directed_rows[k].inv
                                                        : predict_inverse(directed_rows[k].mat));
         send_matrix(directed_rows[k].mat);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            while (inverse_queue.size() != 0) @(posedge clock);
         end
         mat = random_matrix();
         inverse_queue.push_back(predict_inverse(mat));
         send_matrix(mat);
      end
      req_valid <= 1'b0;

      while (inverse_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= ~rsp_stall;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inverse_queue.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = inverse_queue.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: mismatch, expected %h, actual %h", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule
